FILE: hdl/jddm_pkg.sv
// Shared types, codes and constants of the joystick differential-drive mixer.
// Used by every module in this folder; depends on nothing.
`timescale 1ns / 1ps
package jddm_pkg;

	localparam int CURVE_TABLE_DEPTH_DEF = 256;
	localparam int ANGLE_FRAC_BITS_DEF   = 7;

	typedef struct packed {
		logic signed [7:0] dir_x;
		logic signed [7:0] dir_y;
		logic [6:0]        distance;
	} joy_t;

	typedef struct packed {
		logic [3:0] bridge_pattern;
		logic [7:0] left_duty;
		logic [7:0] right_duty;
	} drive_t;

	// Bridge patterns, bit 3 drives in1.
	localparam logic [3:0] PAT_STOP  = 4'b0000;
	localparam logic [3:0] PAT_FWD   = 4'b1010;
	localparam logic [3:0] PAT_BACK  = 4'b0101;
	localparam logic [3:0] PAT_RIGHT = 4'b0110;
	localparam logic [3:0] PAT_LEFT  = 4'b1001;

	// Configuration register indexes.
	localparam int         CFG_IDX_W    = 1;
	localparam logic [0:0] REG_MIN_DUTY = 1'b0;
	localparam logic [0:0] REG_MAX_DUTY = 1'b1;
	localparam logic [7:0] MIN_DUTY_RST = 8'd100;
	localparam logic [7:0] MAX_DUTY_RST = 8'd255;

	// Total pipeline depth: the CORDIC runs in stages 2 to 7 beside the front
	// stages 1 to 4, and the curve stages 8 to 13 follow it.
	localparam int NUM_STAGES = 13;

	// CORDIC in Q20 degrees.
	localparam int CORDIC_STEPS     = 20;
	localparam int CORDIC_PER_STAGE = 4;
	localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
	localparam int CORD_W           = 30;
	localparam int Z_W              = 29;
	localparam logic [25:0] DEG45_Q20 = 26'd47185920;
	localparam logic [25:0] ATAN_Q20 [CORDIC_STEPS] = '{
		26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058,
		26'd1876857,  26'd938658,   26'd469357,   26'd234682,  26'd117342,
		26'd58671,    26'd29335,    26'd14668,    26'd7334,    26'd3667,
		26'd1833,     26'd917,      26'd458,      26'd229,     26'd115
	};

	// Exact division by 10000 for dividends below 2^22.
	localparam logic [22:0] RECIP_10K       = 23'd6871948;
	localparam int          RECIP_10K_SHIFT = 36;
	// Exact division by 45 for dividends below 2^16.
	localparam logic [18:0] RECIP_45        = 19'd372828;
	localparam int          RECIP_45_SHIFT  = 24;
	localparam int          NUM45_W         = 16;

	localparam int RATIO_W = 13;

	// What travels beside the angle path.
	typedef struct packed {
		logic [3:0] pattern;
		logic       xpos;
		logic [7:0] base;
	} side_t;

endpackage

FILE: hdl/jddm_front.sv
// Front stages: input saturation, sector choice and base speed (stages 1 to 4).
// Depends on jddm_pkg.
`timescale 1ns / 1ps
module jddm_front (
	input  logic           clk,
	input  logic [3:0]     load,
	input  jddm_pkg::joy_t joy,
	input  logic [7:0]     min_duty,
	input  logic [7:0]     max_duty,
	output logic [6:0]     m_s1,
	output logic [6:0]     big_s1,
	output jddm_pkg::side_t side_s4
);
	import jddm_pkg::*;

	function automatic logic signed [7:0] sat100(input logic signed [7:0] v);
		if (v > 8'sd100) begin
			return 8'sd100;
		end
		if (v < -8'sd100) begin
			return -8'sd100;
		end
		return v;
	endfunction

	logic signed [7:0] x_c, y_c;
	logic [6:0]        ax_c, ay_c, dist_c;
	logic [3:0]        pat_c;

	logic [3:0]  pat_s1, pat_s2, pat_s3;
	logic        xpos_s1, xpos_s2, xpos_s3;
	logic [13:0] d2_s1;
	logic [21:0] mag_s2;
	logic        neg_s2, neg_s3;
	logic [7:0]  quo_s3;

	logic signed [8:0]  span;
	logic signed [23:0] prod;
	logic [44:0]        qprod;
	logic signed [9:0]  base_sum;

	always_comb begin
		x_c    = sat100(joy.dir_x);
		y_c    = sat100(joy.dir_y);
		ax_c   = x_c[7] ? 7'(-x_c) : x_c[6:0];
		ay_c   = y_c[7] ? 7'(-y_c) : y_c[6:0];
		dist_c = (joy.distance > 7'd100) ? 7'd100 : joy.distance;
		if (x_c == 8'sd0 && y_c == 8'sd0) begin
			pat_c = PAT_STOP;
		end else if (ay_c > ax_c && y_c[7]) begin
			pat_c = PAT_FWD;
		end else if (ay_c > ax_c) begin
			pat_c = PAT_BACK;
		end else if (x_c > 8'sd0) begin
			pat_c = PAT_RIGHT;
		end else begin
			pat_c = PAT_LEFT;
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			pat_s1  <= pat_c;
			xpos_s1 <= (x_c > 8'sd0);
			m_s1    <= (ax_c < ay_c) ? ax_c : ay_c;
			big_s1  <= (ax_c < ay_c) ? ay_c : ax_c;
			d2_s1   <= dist_c * dist_c;
		end
	end

	assign span = $signed({1'b0, max_duty}) - $signed({1'b0, min_duty});
	assign prod = span * $signed({1'b0, d2_s1});

	always_ff @(posedge clk) begin
		if (load[1]) begin
			pat_s2  <= pat_s1;
			xpos_s2 <= xpos_s1;
			neg_s2  <= prod[23];
			mag_s2  <= prod[23] ? 22'(-prod) : prod[21:0];
		end
	end

	// Truncation toward zero: divide the magnitude, restore the sign later.
	assign qprod = mag_s2 * RECIP_10K;

	always_ff @(posedge clk) begin
		if (load[2]) begin
			pat_s3  <= pat_s2;
			xpos_s3 <= xpos_s2;
			neg_s3  <= neg_s2;
			quo_s3  <= qprod[RECIP_10K_SHIFT +: 8];
		end
	end

	assign base_sum = $signed({2'b00, min_duty})
		+ (neg_s3 ? -$signed({2'b00, quo_s3}) : $signed({2'b00, quo_s3}));

	always_ff @(posedge clk) begin
		if (load[3]) begin
			side_s4.pattern <= pat_s3;
			side_s4.xpos    <= xpos_s3;
			side_s4.base    <= base_sum[7:0];
		end
	end

endmodule

FILE: hdl/jddm_cordic.sv
// Vectoring CORDIC for the deviation angle, four iterations per stage.
// Stages 2 to 7 of the pipeline; depends on jddm_pkg.
`timescale 1ns / 1ps
module jddm_cordic (
	input  logic                        clk,
	input  logic [5:0]                  load,
	input  logic [6:0]                  m_s1,
	input  logic [6:0]                  big_s1,
	output logic signed [jddm_pkg::Z_W-1:0] z_s7,
	output logic                        zero_s7,
	output logic                        diag_s7
);
	import jddm_pkg::*;

	logic signed [CORD_W-1:0] x_st [CORDIC_STAGES+1];
	logic signed [CORD_W-1:0] y_st [CORDIC_STAGES+1];
	logic signed [Z_W-1:0]    z_st [CORDIC_STAGES+1];
	logic                     zero_st [CORDIC_STAGES+1];
	logic                     diag_st [CORDIC_STAGES+1];

	always_ff @(posedge clk) begin
		if (load[0]) begin
			x_st[0]    <= $signed({3'b000, big_s1, 20'd0});
			y_st[0]    <= $signed({3'b000, m_s1, 20'd0});
			z_st[0]    <= '0;
			zero_st[0] <= (m_s1 == 7'd0);
			diag_st[0] <= (m_s1 == big_s1);
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		logic signed [CORD_W-1:0] xi [CORDIC_PER_STAGE+1];
		logic signed [CORD_W-1:0] yi [CORDIC_PER_STAGE+1];
		logic signed [Z_W-1:0]    zi [CORDIC_PER_STAGE+1];

		always_comb begin
			xi[0] = x_st[g];
			yi[0] = y_st[g];
			zi[0] = z_st[g];
			for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
				if (yi[k] >= 0) begin
					xi[k+1] = xi[k] + (yi[k] >>> (g * CORDIC_PER_STAGE + k));
					yi[k+1] = yi[k] - (xi[k] >>> (g * CORDIC_PER_STAGE + k));
					zi[k+1] = zi[k] + $signed({3'b000, ATAN_Q20[g * CORDIC_PER_STAGE + k]});
				end else begin
					xi[k+1] = xi[k] - (yi[k] >>> (g * CORDIC_PER_STAGE + k));
					yi[k+1] = yi[k] + (xi[k] >>> (g * CORDIC_PER_STAGE + k));
					zi[k+1] = zi[k] - $signed({3'b000, ATAN_Q20[g * CORDIC_PER_STAGE + k]});
				end
			end
		end

		always_ff @(posedge clk) begin
			if (load[g+1]) begin
				x_st[g+1]    <= xi[CORDIC_PER_STAGE];
				y_st[g+1]    <= yi[CORDIC_PER_STAGE];
				z_st[g+1]    <= zi[CORDIC_PER_STAGE];
				zero_st[g+1] <= zero_st[g];
				diag_st[g+1] <= diag_st[g];
			end
		end
	end

	assign z_s7    = z_st[CORDIC_STAGES];
	assign zero_s7 = zero_st[CORDIC_STAGES];
	assign diag_s7 = diag_st[CORDIC_STAGES];

endmodule

FILE: hdl/jddm_curve.sv
// Curve stages: angle rounding, table index, curve lookup, wheel scaling and
// duty clamp (stages 8 to 13). Depends on jddm_pkg.
`timescale 1ns / 1ps
module jddm_curve #(
	parameter int CURVE_TABLE_DEPTH = jddm_pkg::CURVE_TABLE_DEPTH_DEF,
	parameter int ANGLE_FRAC_BITS   = jddm_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic [5:0]                      load,
	input  logic signed [jddm_pkg::Z_W-1:0] z_s7,
	input  logic                            zero_s7,
	input  logic                            diag_s7,
	input  jddm_pkg::side_t                 side_s7,
	input  logic [7:0]                      min_duty,
	input  logic [7:0]                      max_duty,
	output jddm_pkg::drive_t                drive_s13
);
	import jddm_pkg::*;

	localparam int F       = ANGLE_FRAC_BITS;
	localparam int D       = CURVE_TABLE_DEPTH;
	localparam int IDX_W   = $clog2(D);
	localparam int FULL    = 45 << F;
	localparam int DEV_W   = $clog2(FULL + 1);
	localparam int NPROD_W = DEV_W + IDX_W + 1;
	localparam int TAB_W   = D * RATIO_W;

	// Shift-and-subtract quotient, used only while the tables are built.
	function automatic longint unsigned udiv(input longint unsigned a,
		input longint unsigned d);
		longint unsigned q, r;
		q = 0;
		r = 0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[62:0], a[k]};
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// Curve tables, built once at elaboration in Q12.
	function automatic longint unsigned isqrt(input longint unsigned v_in);
		longint unsigned v, r, b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	function automatic longint unsigned root5(input longint unsigned b);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 4096;
		for (int k = 0; k < 14; k++) begin
			if (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (mid * mid * mid * mid * mid <= b) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
		end
		return lo;
	endfunction

	function automatic logic [TAB_W-1:0] build_tab(input bit turn);
		logic [TAB_W-1:0] t;
		longint unsigned  n, i, p15, b, e, q;
		t = '0;
		n = longint'(D - 1);
		for (int j = 0; j < D; j++) begin
			i   = longint'(j);
			p15 = isqrt(udiv((i * i * i) << 24, n * n * n));
			b   = 64'd1 << 60;
			for (int k = 0; k < 6; k++) begin
				q = udiv(b, n);
				b = q * i + udiv((b - q * n) * i, n);
			end
			if (turn) begin
				e = udiv(64'd122880 + 64'd21 * root5(b) + 64'd50, 64'd100);
			end else begin
				e = 64'd4096 - udiv(64'd7 * p15 + 64'd5, 64'd10);
			end
			t[j*RATIO_W +: RATIO_W] = RATIO_W'(e);
		end
		return t;
	endfunction

	localparam logic [TAB_W-1:0] STEER_TAB = build_tab(1'b0);
	localparam logic [TAB_W-1:0] TURN_TAB  = build_tab(1'b1);

	localparam logic [26:0]        ROUND_ADD = 27'(1) << (19 - F);
	localparam logic [DEV_W-1:0]   DEV_FULL  = DEV_W'(FULL);
	localparam logic [NPROD_W-1:0] HALF      = NPROD_W'(FULL / 2);
	localparam logic [IDX_W:0]     IDX_MAX   = (IDX_W + 1)'(D - 1);

	side_t side_s8, side_s9, side_s10, side_s11;
	logic [3:0] pat_s12;

	logic [25:0]        zc;
	logic [26:0]        zr;
	logic [DEV_W-1:0]   dev_s8;
	logic [NPROD_W-1:0] nprod;
	logic [NUM45_W-1:0] num_s9;
	logic [34:0]        qprod;
	logic [IDX_W:0]     qidx;
	logic [IDX_W-1:0]   idx_s10;
	logic [RATIO_W-1:0] ratio_s11;
	logic [20:0]        sprod;
	logic [7:0]         scaled;
	logic               scale_right;
	logic [7:0]         left_s12, right_s12;

	always_comb begin
		if (z_s7 < 0) begin
			zc = '0;
		end else if (z_s7 > $signed({3'b000, DEG45_Q20})) begin
			zc = DEG45_Q20;
		end else begin
			zc = z_s7[25:0];
		end
		zr = {1'b0, zc} + ROUND_ADD;
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			side_s8 <= side_s7;
			if (zero_s7) begin
				dev_s8 <= '0;
			end else if (diag_s7) begin
				dev_s8 <= DEV_FULL;
			end else begin
				dev_s8 <= zr[20-F +: DEV_W];
			end
		end
	end

	// Rounded index: divide by 2^F here, by 45 in the next stage.
	assign nprod = NPROD_W'(dev_s8 * (D - 1)) + HALF;

	always_ff @(posedge clk) begin
		if (load[1]) begin
			side_s9 <= side_s8;
			num_s9  <= NUM45_W'(nprod >> F);
		end
	end

	assign qprod = num_s9 * RECIP_45;
	assign qidx  = qprod[RECIP_45_SHIFT +: IDX_W + 1];

	always_ff @(posedge clk) begin
		if (load[2]) begin
			side_s10 <= side_s9;
			idx_s10  <= (qidx > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : qidx[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load[3]) begin
			side_s11 <= side_s10;
			if (side_s10.pattern == PAT_RIGHT || side_s10.pattern == PAT_LEFT) begin
				ratio_s11 <= TURN_TAB[RATIO_W * idx_s10 +: RATIO_W];
			end else begin
				ratio_s11 <= STEER_TAB[RATIO_W * idx_s10 +: RATIO_W];
			end
		end
	end

	// The ratio never exceeds one, so the scaled duty fits in eight bits.
	assign sprod  = side_s11.base * ratio_s11;
	assign scaled = sprod[19:12];

	always_comb begin
		case (side_s11.pattern)
			PAT_FWD:   scale_right = side_s11.xpos;
			PAT_BACK:  scale_right = !side_s11.xpos;
			PAT_RIGHT: scale_right = 1'b1;
			default:   scale_right = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load[4]) begin
			pat_s12   <= side_s11.pattern;
			left_s12  <= scale_right ? side_s11.base : scaled;
			right_s12 <= scale_right ? scaled : side_s11.base;
		end
	end

	function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] lo,
		input logic [7:0] hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	always_ff @(posedge clk) begin
		if (load[5]) begin
			drive_s13.bridge_pattern <= pat_s12;
			if (pat_s12 == PAT_STOP) begin
				drive_s13.left_duty  <= '0;
				drive_s13.right_duty <= '0;
			end else begin
				drive_s13.left_duty  <= clamp(left_s12, min_duty, max_duty);
				drive_s13.right_duty <= clamp(right_s12, min_duty, max_duty);
			end
		end
	end

endmodule

FILE: hdl/joystick_differential_drive_mixer.sv
// Top level of the joystick differential-drive mixer: configuration registers,
// pipeline valid bits and stall handling. Depends on jddm_pkg, jddm_front,
// jddm_cordic and jddm_curve.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   joy      | joy_valid / joy_stall    | joy   (dir_x, dir_y, distance)
//   drive    | drive_valid / drive_stall| drive (bridge_pattern, duties)
//   cfg      | cfg_we                   | cfg_index, cfg_data
//
// A transaction on joy yields one transaction on drive; the 20-iteration
// CORDIC is spread over five stages. One transaction is accepted every cycle
// unless joy_stall is raised. Each stage holds its item only while
// the stage after it is full and held, so bubbles close up under a drive stall.
// Reset clears all valid bits and loads the duty limits 100 and 255; the curve
// tables are constants and need no fill time.
`timescale 1ns / 1ps
module joystick_differential_drive_mixer #(
	parameter int CURVE_TABLE_DEPTH = jddm_pkg::CURVE_TABLE_DEPTH_DEF,
	parameter int ANGLE_FRAC_BITS   = jddm_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               joy_valid,
	output logic                               joy_stall,
	input  jddm_pkg::joy_t                     joy,
	output logic                               drive_valid,
	input  logic                               drive_stall,
	output jddm_pkg::drive_t                   drive,
	input  logic                               cfg_we,
	input  logic [jddm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_data
);
	import jddm_pkg::*;

	logic [7:0] min_duty_q, max_duty_q;
	logic [NUM_STAGES:1] valid_q;
	logic [NUM_STAGES:1] load;

	logic [6:0]            m_s1, big_s1;
	side_t                 side_s4, side_s5, side_s6, side_s7;
	logic signed [Z_W-1:0] z_s7;
	logic                  zero_s7, diag_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duty_q <= MIN_DUTY_RST;
			max_duty_q <= MAX_DUTY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_DUTY: min_duty_q <= cfg_data;
				REG_MAX_DUTY: max_duty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its content moves on.
	always_comb begin
		load[NUM_STAGES] = !valid_q[NUM_STAGES] || !drive_stall;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[1]) begin
				valid_q[1] <= joy_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign joy_stall   = !load[1];
	assign drive_valid = valid_q[NUM_STAGES];

	jddm_front u_front (
		.clk      (clk),
		.load     (load[4:1]),
		.joy      (joy),
		.min_duty (min_duty_q),
		.max_duty (max_duty_q),
		.m_s1     (m_s1),
		.big_s1   (big_s1),
		.side_s4  (side_s4)
	);

	jddm_cordic u_cordic (
		.clk     (clk),
		.load    (load[7:2]),
		.m_s1    (m_s1),
		.big_s1  (big_s1),
		.z_s7    (z_s7),
		.zero_s7 (zero_s7),
		.diag_s7 (diag_s7)
	);

	always_ff @(posedge clk) begin
		if (load[5]) begin
			side_s5 <= side_s4;
		end
		if (load[6]) begin
			side_s6 <= side_s5;
		end
		if (load[7]) begin
			side_s7 <= side_s6;
		end
	end

	jddm_curve #(
		.CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH),
		.ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
	) u_curve (
		.clk       (clk),
		.load      (load[13:8]),
		.z_s7      (z_s7),
		.zero_s7   (zero_s7),
		.diag_s7   (diag_s7),
		.side_s7   (side_s7),
		.min_duty  (min_duty_q),
		.max_duty  (max_duty_q),
		.drive_s13 (drive)
	);

	// An accepted transaction always lands in the first stage.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		joy_valid && !joy_stall |=> valid_q[1])
		else $error("accepted transaction did not enter stage 1");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive.bridge_pattern == PAT_STOP
		|-> drive.left_duty == 8'd0 && drive.right_duty == 8'd0)
		else $error("stop result with nonzero duty");

	a_pattern_legal: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> drive.bridge_pattern == PAT_STOP || drive.bridge_pattern == PAT_FWD
		|| drive.bridge_pattern == PAT_BACK || drive.bridge_pattern == PAT_RIGHT
		|| drive.bridge_pattern == PAT_LEFT)
		else $error("illegal bridge pattern");

	// A full last stage that is held keeps the whole chain from losing items.
	a_hold_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall && (&valid_q) |-> joy_stall)
		else $error("full pipeline accepted a transaction under stall");

endmodule

FILE: bench/tb_joystick_differential_drive_mixer.sv
// Self-checking testbench of the joystick differential-drive mixer.
// Depends on jddm_pkg and joystick_differential_drive_mixer; predicts each drive result.
`timescale 1ns / 1ps
module tb_joystick_differential_drive_mixer;
	import jddm_pkg::*;

	localparam int DEPTH = CURVE_TABLE_DEPTH_DEF;
	localparam int FRAC = ANGLE_FRAC_BITS_DEF;
	localparam int LATENCY = NUM_STAGES;
	localparam int RANDOM_ITEMS = 1400;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic joy_valid;
	logic joy_stall;
	joy_t joy;
	logic drive_valid;
	logic drive_stall;
	drive_t drive;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	longint cycles;
	bit quiet_recv;
	int num_sent;

	joystick_differential_drive_mixer uut (
		.clk(clk), .arst_n(arst_n),
		.joy_valid(joy_valid), .joy_stall(joy_stall), .joy(joy),
		.drive_valid(drive_valid), .drive_stall(drive_stall), .drive(drive),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	class mixer_scoreboard;
		int unsigned steer_curve[DEPTH];
		int unsigned turn_curve[DEPTH];
		int unsigned min_duty;
		int unsigned max_duty;
		drive_t pending[$];
		int errors;
		int checked;

		function new();
			longint unsigned n, b, p15, lo, hi, mid;
			n = DEPTH - 1;
			for (int i = 0; i < DEPTH; i++) begin
				p15 = int_sqrt(((longint'(i) * i * i) << 24) / (n * n * n));
				b = 64'd1 << 60;
				for (int k = 0; k < 6; k++)
					b = (b / n) * i + ((b % n) * i) / n;
				lo = 0;
				hi = 4096;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					if (mid * mid * mid * mid * mid <= b)
						lo = mid;
					else
						hi = mid - 1;
				end
				steer_curve[i] = 32'(4096 - (7 * p15 + 5) / 10);
				turn_curve[i] = 32'((122880 + 21 * lo + 50) / 100);
			end
			min_duty = MIN_DUTY_RST;
			max_duty = MAX_DUTY_RST;
			errors = 0;
			checked = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, bt;
			r = 0;
			bt = 64'd1 << 62;
			while (bt > v) bt >>= 2;
			while (bt != 0) begin
				if (v >= r + bt) begin
					v -= r + bt;
					r = (r >> 1) + bt;
				end else begin
					r >>= 1;
				end
				bt >>= 2;
			end
			return r;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx == REG_MIN_DUTY)
				min_duty = val;
			else if (idx == REG_MAX_DUTY)
				max_duty = val;
		endfunction

		// Arctangent of m/big in degrees with FRAC fraction bits, vectoring CORDIC.
		function int unsigned angle_of(int m, int big);
			longint xs, ys, z, dx, dy;
			if (m == 0)
				return 0;
			if (m == big)
				return 45 << FRAC;
			xs = longint'(big) <<< 20;
			ys = longint'(m) <<< 20;
			z = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = ys >>> i;
				dy = xs >>> i;
				if (ys >= 0) begin
					xs += dx; ys -= dy; z += longint'(ATAN_Q20[i]);
				end else begin
					xs -= dx; ys += dy; z -= longint'(ATAN_Q20[i]);
				end
			end
			if (z < 0) z = 0;
			if (z > longint'(DEG45_Q20)) z = DEG45_Q20;
			return int'((z + (longint'(1) << (19 - FRAC))) >> (20 - FRAC));
		endfunction

		function int unsigned limit_duty(int unsigned v);
			if (v < min_duty) return min_duty;
			if (v > max_duty) return max_duty;
			return v;
		endfunction

		function int saturate(logic signed [7:0] v);
			if (v > 100) return 100;
			if (v < -100) return -100;
			return v;
		endfunction

		function void note_joy(joy_t j);
			int x, y, d, ax, ay, m, big, span;
			int unsigned base, dev, full, idx, left, right;
			drive_t r;
			x = saturate(j.dir_x);
			y = saturate(j.dir_y);
			d = (j.distance > 100) ? 100 : j.distance;
			if (x == 0 && y == 0) begin
				r.bridge_pattern = PAT_STOP;
				r.left_duty = '0;
				r.right_duty = '0;
				pending.push_back(r);
				return;
			end
			span = int'(max_duty) - int'(min_duty);
			base = int'(min_duty) + (span * d * d) / 10000;
			ax = x < 0 ? -x : x;
			ay = y < 0 ? -y : y;
			m = ax < ay ? ax : ay;
			big = ax < ay ? ay : ax;
			dev = angle_of(m, big);
			full = 45 << FRAC;
			idx = (dev * (DEPTH - 1) + full / 2) / full;
			if (idx > DEPTH - 1) idx = DEPTH - 1;
			left = base;
			right = base;
			if (ay > ax && y < 0) begin
				r.bridge_pattern = PAT_FWD;
				if (x > 0) right = (base * steer_curve[idx]) >> 12;
				else left = (base * steer_curve[idx]) >> 12;
			end else if (ay > ax) begin
				r.bridge_pattern = PAT_BACK;
				if (x > 0) left = (base * steer_curve[idx]) >> 12;
				else right = (base * steer_curve[idx]) >> 12;
			end else if (x > 0) begin
				r.bridge_pattern = PAT_RIGHT;
				right = (base * turn_curve[idx]) >> 12;
			end else begin
				r.bridge_pattern = PAT_LEFT;
				left = (base * turn_curve[idx]) >> 12;
			end
			r.left_duty = 8'(limit_duty(left));
			r.right_duty = 8'(limit_duty(right));
			pending.push_back(r);
		endfunction

		function void check_drive(drive_t got);
			drive_t want;
			if (pending.size() == 0) begin
				$error("drive transaction with nothing expected: %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.bridge_pattern !== want.bridge_pattern) begin
				$error("bridge_pattern: expected %0d, got %0d", want.bridge_pattern,
					got.bridge_pattern);
				errors++;
			end
			if (got.left_duty !== want.left_duty) begin
				$error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
				errors++;
			end
			if (got.right_duty !== want.right_duty) begin
				$error("right_duty: expected %0d, got %0d", want.right_duty, got.right_duty);
				errors++;
			end
		endfunction
	endclass

	mixer_scoreboard drive_book;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: sample at the rising edge, change stall at the falling edge.
	always @(posedge clk)
		if (arst_n && drive_valid && !drive_stall)
			drive_book.check_drive(drive);

	always @(negedge clk)
		drive_stall <= (!quiet_recv && $urandom_range(99) < 7);

	// Called and returns at a falling edge; the enable drops at a falling edge of its own
	// before the return, so back-to-back writes never assign it twice at once.
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		drive_book.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (drive_book.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Sends one transaction; called and returns at a falling edge.
	task automatic send_joy(logic signed [7:0] x, logic signed [7:0] y, logic [6:0] d,
			bit gaps);
		joy_t j;
		j.dir_x = x;
		j.dir_y = y;
		j.distance = d;
		while (gaps && $urandom_range(99) < 7) begin
			joy_valid <= 1'b0;
			@(negedge clk);
		end
		joy_valid <= 1'b1;
		joy <= j;
		do @(posedge clk); while (joy_stall);
		drive_book.note_joy(j);
		num_sent++;
		@(negedge clk);
	endtask

	task automatic random_joy(bit gaps);
		logic signed [7:0] x, y;
		logic [6:0] d;
		int sel;
		sel = $urandom_range(9);
		x = (sel < 7) ? $signed(8'($urandom_range(200) - 100)) : 8'($urandom);
		y = (sel < 7) ? $signed(8'($urandom_range(200) - 100)) : 8'($urandom);
		if (sel == 7) y = ($urandom_range(1)) ? x : -x;
		if (sel == 8) x = 0;
		if (sel == 9 && $urandom_range(1)) y = 0;
		d = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(100));
		send_joy(x, y, d, gaps);
	endtask

	initial begin
		logic [7:0] lo_set[5];
		logic [7:0] hi_set[5];
		lo_set = '{8'd100, 8'd0, 8'd0, 8'd255, 8'd200};
		hi_set = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd50};
		drive_book = new();
		cycles = 0;
		num_sent = 0;
		quiet_recv = 1'b0;
		arst_n = 1'b0;
		joy_valid = 1'b0;
		joy = '0;
		drive_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_DUTY;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed corners at reset limits: stop, each sector, ties, saturation.
		send_joy(0, 0, 100, 0);
		send_joy(0, -100, 100, 0);
		send_joy(0, 100, 50, 0);
		send_joy(100, 0, 100, 0);
		send_joy(-100, 0, 0, 0);
		send_joy(30, -60, 70, 0);
		send_joy(-30, -60, 70, 0);
		send_joy(30, 60, 70, 0);
		send_joy(-30, 60, 70, 0);
		send_joy(50, 50, 100, 0);
		send_joy(-50, 50, 100, 0);
		send_joy(50, -50, 100, 0);
		send_joy(-50, -50, 100, 0);
		send_joy(127, -128, 127, 0);
		send_joy(-128, 127, 101, 0);
		send_joy(1, -100, 1, 0);
		send_joy(100, 1, 99, 0);
		send_joy(-1, 0, 127, 0);
		send_joy(8'h55, 8'hAA, 7'h55, 0);
		send_joy(8'hAA, 8'h55, 7'h2A, 0);
		joy_valid <= 1'b0;
		drain();

		// Each phase uses a different duty window, including inverted and flat ones.
		for (int p = 0; p < 5; p++) begin
			write_cfg(REG_MIN_DUTY, lo_set[p]);
			write_cfg(REG_MAX_DUTY, hi_set[p]);
			for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
				// A back-to-back stretch with neither side idling.
				quiet_recv = (p == 1 && i >= 50 && i < 200);
				random_joy(!quiet_recv);
				if (p == 2 && i == 100) begin
					joy_valid <= 1'b0;
					while (drive_book.pending.size() != 0) @(negedge clk);
				end
			end
			joy_valid <= 1'b0;
			quiet_recv = 1'b0;
			drain();
		end

		$display("Sent %0d joystick moves over five duty windows; checked %0d drive results.",
			num_sent, drive_book.checked);
		if (drive_book.errors == 0 && drive_book.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: sim.f
hdl/jddm_pkg.sv
hdl/jddm_front.sv
hdl/jddm_cordic.sv
hdl/jddm_curve.sv
hdl/joystick_differential_drive_mixer.sv
bench/tb_joystick_differential_drive_mixer.sv
